### design/pds_pkg.sv
// Package for the parachute deploy sequencer: timing constants, sequence states,
// command codes, the result record and the flight countdown table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

	localparam int TICKS_PER_SEC = 1000;

	localparam int LEN_OPEN_MAX = (255 * TICKS_PER_SEC) / 10;
	localparam int LEN_MAX = (LEN_OPEN_MAX > 5 * TICKS_PER_SEC) ? LEN_OPEN_MAX
		: 5 * TICKS_PER_SEC;
	localparam int CNT_W = $clog2(LEN_MAX + 1);

	localparam logic [CNT_W-1:0] LEN_INIT = CNT_W'(1 * TICKS_PER_SEC);
	localparam logic [CNT_W-1:0] LEN_OPENING = CNT_W'(5 * TICKS_PER_SEC);
	localparam logic [CNT_W-1:0] LEN_CLOSING = CNT_W'(2 * TICKS_PER_SEC);

	localparam logic [7:0] SUB_WRITE = 8'h00;
	localparam logic [7:0] SUB_READ = 8'hff;

	localparam logic [2:0] KIND_TAKE_OFF = 3'd0;
	localparam logic [2:0] KIND_OPEN_TIME = 3'd1;
	localparam logic [2:0] KIND_STATE = 3'd2;
	localparam logic [2:0] KIND_APP_START = 3'd3;

	localparam logic MODE_TICK = 1'b0;

	localparam logic RES_PRESET = 1'b0;
	localparam logic RES_RESPONSE = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT = 3'd0,
		ST_OPENING = 3'd1,
		ST_CLOSING = 3'd2,
		ST_WAITING = 3'd3,
		ST_FLIGHT = 3'd4,
		ST_PARACHUTE = 3'd5
	} seq_state_t;

	typedef struct packed {
		logic       result_kind;
		logic [2:0] container_num;
		logic [7:0] resp_source;
		logic [7:0] resp_dest;
		logic [2:0] resp_kind;
		logic [7:0] resp_arg_zero;
		logic [7:0] resp_arg_one;
		logic       resp_error;
		logic       last;
	} result_t;

	typedef logic [CNT_W-1:0] len_tab_t [256];

	function automatic len_tab_t build_flight_tab();
		len_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = CNT_W'((longint'(i) * TICKS_PER_SEC) / 10);
		end
		return tab;
	endfunction

	localparam len_tab_t FLIGHT_LEN = build_flight_tab();

endpackage

`default_nettype wire

### design/parachute_deploy_sequencer.sv
// Parachute deploy sequencer: sequence state, countdown and open-time register,
// with a four-entry result queue toward the output channel.
// Depends on pds_pkg.
//
// A request is decoded in the cycle it is accepted, and its results are registered
// into the result queue. Throughput: one request per cycle while the result queue
// has room for two results; a take-off in the waiting state yields two results.
// Asynchronous active-low reset returns to the init state, unarmed, with no
// countdown, open time zero and an empty result queue.
`timescale 1ns / 1ps
`default_nettype none

module parachute_deploy_sequencer
	import pds_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       mode,
	input  wire logic [2:0] cmd_kind,
	input  wire logic [7:0] arg_zero,
	input  wire logic [7:0] arg_one,
	input  wire logic       is_response,
	input  wire logic [7:0] source_addr,
	input  wire logic [7:0] dest_addr,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            result_kind,
	output logic [2:0]      container_num,
	output logic [7:0]      resp_source,
	output logic [7:0]      resp_dest,
	output logic [2:0]      resp_kind,
	output logic [7:0]      resp_arg_zero,
	output logic [7:0]      resp_arg_one,
	output logic            resp_error,
	output logic            last
);

	seq_state_t       state_q, state_nxt;
	logic             armed_q, armed_nxt;
	logic [CNT_W-1:0] countdown_q, countdown_nxt;
	logic             active_q, active_nxt;
	logic [7:0]       open_q, open_nxt;

	result_t    res_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	result_t    res0, res1, preset;
	logic [1:0] n_push;
	logic       in_acc, out_acc;
	logic       do_enter, has_resp;
	seq_state_t enter_st;

	assign in_stall = (count_q > 3'd2);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (count_q != 3'd0);
	assign out_acc = out_valid && !out_stall;

	always_comb begin
		state_nxt = state_q;
		armed_nxt = armed_q;
		countdown_nxt = countdown_q;
		active_nxt = active_q;
		open_nxt = open_q;
		do_enter = 1'b0;
		has_resp = 1'b0;
		enter_st = ST_INIT;
		res0 = '0;
		res1 = '0;
		preset = '0;
		n_push = 2'd0;

		if (in_acc) begin
			if (mode == MODE_TICK) begin
				if (armed_q && active_q) begin
					if (countdown_q != '0) begin
						countdown_nxt = countdown_q - 1'b1;
					end else begin
						active_nxt = 1'b0;
						case (state_q)
							ST_INIT: begin
								enter_st = ST_OPENING;
								do_enter = 1'b1;
							end
							ST_OPENING: begin
								enter_st = ST_CLOSING;
								do_enter = 1'b1;
							end
							ST_CLOSING: begin
								enter_st = ST_WAITING;
								do_enter = 1'b1;
							end
							ST_FLIGHT: begin
								enter_st = ST_PARACHUTE;
								do_enter = 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
			end else if (!is_response && cmd_kind != KIND_STATE) begin
				if (cmd_kind == KIND_APP_START) begin
					if (!armed_q) begin
						armed_nxt = 1'b1;
						enter_st = ST_INIT;
						do_enter = 1'b1;
					end
				end else begin
					has_resp = 1'b1;
					res0.result_kind = RES_RESPONSE;
					res0.resp_source = dest_addr;
					res0.resp_dest = source_addr;
					res0.resp_kind = cmd_kind;
					res0.resp_arg_zero = arg_zero;
					res0.resp_arg_one = arg_one;
					res0.last = 1'b1;
					if (cmd_kind == KIND_OPEN_TIME) begin
						if (arg_zero == SUB_WRITE) begin
							open_nxt = arg_one;
						end else if (arg_zero == SUB_READ) begin
							res0.resp_arg_one = open_q;
						end else begin
							res0.resp_error = 1'b1;
						end
					end
					if (cmd_kind == KIND_TAKE_OFF && armed_q && state_q == ST_WAITING) begin
						res0.last = 1'b0;
						enter_st = ST_FLIGHT;
						do_enter = 1'b1;
					end
				end
			end
		end

		if (do_enter) begin
			state_nxt = enter_st;
			countdown_nxt = '0;
			active_nxt = 1'b0;
			case (enter_st)
				ST_INIT: begin
					countdown_nxt = LEN_INIT;
					active_nxt = 1'b1;
				end
				ST_OPENING: begin
					countdown_nxt = LEN_OPENING;
					active_nxt = 1'b1;
				end
				ST_CLOSING: begin
					countdown_nxt = LEN_CLOSING;
					active_nxt = 1'b1;
				end
				ST_FLIGHT: begin
					countdown_nxt = FLIGHT_LEN[open_q];
					active_nxt = 1'b1;
				end
				default: begin
				end
			endcase
			preset.result_kind = RES_PRESET;
			preset.container_num = 3'(enter_st) + 3'd1;
			preset.last = 1'b1;
		end

		if (has_resp && do_enter) begin
			res1 = preset;
			n_push = 2'd2;
		end else if (has_resp) begin
			n_push = 2'd1;
		end else if (do_enter) begin
			res0 = preset;
			n_push = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			armed_q <= 1'b0;
			countdown_q <= '0;
			active_q <= 1'b0;
			open_q <= 8'd0;
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q <= 3'd0;
		end else begin
			state_q <= state_nxt;
			armed_q <= armed_nxt;
			countdown_q <= countdown_nxt;
			active_q <= active_nxt;
			open_q <= open_nxt;
			wr_ptr_q <= wr_ptr_q + n_push;
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, n_push} - {2'b00, out_acc};
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			res_q[wr_ptr_q] <= res0;
		end
		if (n_push == 2'd2) begin
			res_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	assign result_kind = res_q[rd_ptr_q].result_kind;
	assign container_num = res_q[rd_ptr_q].container_num;
	assign resp_source = res_q[rd_ptr_q].resp_source;
	assign resp_dest = res_q[rd_ptr_q].resp_dest;
	assign resp_kind = res_q[rd_ptr_q].resp_kind;
	assign resp_arg_zero = res_q[rd_ptr_q].resp_arg_zero;
	assign resp_arg_one = res_q[rd_ptr_q].resp_arg_one;
	assign resp_error = res_q[rd_ptr_q].resp_error;
	assign last = res_q[rd_ptr_q].last;

endmodule

`default_nettype wire
